// ----- hw/rtl/pfc_pkg.sv -----
// pfc_pkg: types, codes and constants shared by the Playfair encrypt core.
// No dependencies.
package pfc_pkg;

	// input op codes
	localparam logic [1:0] OP_KEY    = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_MSG    = 2'd2;
	localparam logic [1:0] OP_END    = 2'd3;

	// letter indexes, a = 0
	localparam logic [4:0] LTR_I    = 5'd8;
	localparam logic [4:0] LTR_J    = 5'd9;
	localparam logic [4:0] LTR_X    = 5'd23;
	localparam logic [4:0] LTR_LAST = 5'd25;

	localparam int unsigned N_LETTERS = 26;
	localparam int unsigned SQ_CELLS  = 25;
	localparam logic [2:0]  SIDE      = 3'd5;
	localparam logic [2:0]  SIDE_MAX  = 3'd4;

	localparam logic [7:0] ASC_UP_A = 8'd65;
	localparam logic [7:0] ASC_UP_Z = 8'd90;
	localparam logic [7:0] ASC_LO_A = 8'd97;
	localparam logic [7:0] ASC_LO_Z = 8'd122;
	localparam logic [6:0] OUT_BASE = 7'd97;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] letter;
	} in_item_t;

	typedef struct packed {
		logic [6:0] cipher_letter;
		logic       pair_last;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_KEY,
		CMD_FIN,
		CMD_MSG,
		CMD_END
	} cmd_kind_t;

	// classified command passed from front to back
	typedef struct packed {
		cmd_kind_t  kind;
		logic       is_letter;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FILL,
		BK_LOOK,
		BK_OUT0,
		BK_OUT1
	} back_state_t;

endpackage

// ----- hw/rtl/pfc_front.sv -----
// pfc_front: folds raw input bytes to letter indexes and classifies items.
// Depends on pfc_pkg.
module pfc_front import pfc_pkg::*; (
	input  logic     item_valid,
	input  in_item_t item,
	input  logic     q_full,
	output logic     item_stall,
	output push_t    wr
);

	logic [7:0] lower;
	logic [7:0] offs;
	logic       is_letter;
	logic [4:0] idx;

	always_comb begin
		lower = item.letter;
		if (item.letter >= ASC_UP_A && item.letter <= ASC_UP_Z) begin
			lower = item.letter | 8'h20;
		end
		is_letter = (lower >= ASC_LO_A) && (lower <= ASC_LO_Z);
		offs = lower - ASC_LO_A;
		idx = offs[4:0];
		if (idx == LTR_J) begin
			idx = LTR_I;
		end
	end

	assign item_stall = q_full;

	always_comb begin
		wr.cmd.is_letter = is_letter;
		wr.cmd.idx = idx;
		unique case (item.op)
			OP_KEY:    wr.cmd.kind = CMD_KEY;
			OP_FINISH: wr.cmd.kind = CMD_FIN;
			OP_MSG:    wr.cmd.kind = CMD_MSG;
			default:   wr.cmd.kind = CMD_END;
		endcase
		// a message non-letter has no effect at all: drop it here
		wr.push = item_valid && !q_full && !(item.op == OP_MSG && !is_letter);
	end

endmodule

// ----- hw/rtl/pfc_queue.sv -----
// pfc_queue: small command FIFO between front and back.
// Depends on pfc_pkg.
module pfc_queue import pfc_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t wr,
	input  logic  pop,
	output logic  full,
	output logic  q_valid,
	output cmd_t  rd_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr.push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!wr.push && pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH)) else $error("queue count above depth");

endmodule

// ----- hw/rtl/pfc_back.sv -----
// pfc_back: key square build, alphabet fill sweep and pair encryption.
// Holds the square and letter position memories. Depends on pfc_pkg.
module pfc_back import pfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  cmd_t      cmd,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	back_state_t st_q, st_d;

	// memories: square cell -> letter, letter -> {row, col}
	logic [4:0] sq_mem [SQ_CELLS];
	logic [5:0] rc_mem [N_LETTERS];

	logic [N_LETTERS-1:0] used_q, used_d, base_used;
	logic [2:0] frow_q, frow_d, base_row;
	logic [2:0] fcol_q, fcol_d, base_col;
	logic [4:0] pend_q, pend_d;
	logic       pvld_q, pvld_d;
	logic       kd_q, kd_d;
	logic [4:0] fidx_q, fidx_d;

	logic       do_place, can_place;
	logic [4:0] place_idx;
	logic [4:0] wr_pos;

	logic       rc_rd_en, sq_rd_en, go_fill;
	logic [4:0] rd_b;
	logic [5:0] rc_a_q, rc_b_q;
	logic [4:0] sq1_q, sq2_q;
	logic [2:0] ra, ca, rb, cb;
	logic [4:0] pos1, pos2;

	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		wrap_inc = (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
	endfunction

	function automatic logic [4:0] cell_pos(input logic [2:0] r, input logic [2:0] c);
		cell_pos = {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

	// datapath control
	always_comb begin
		base_used = used_q;
		base_row  = frow_q;
		base_col  = fcol_q;
		do_place  = 1'b0;
		place_idx = cmd.idx;
		pend_d    = pend_q;
		pvld_d    = pvld_q;
		kd_d      = kd_q;
		fidx_d    = fidx_q;
		rc_rd_en  = 1'b0;
		sq_rd_en  = 1'b0;
		go_fill   = 1'b0;
		rd_b      = LTR_X;
		pop       = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					unique case (cmd.kind)
						CMD_KEY: begin
							// a key item after finish starts a new key
							if (kd_q) begin
								base_used = '0;
								base_row  = '0;
								base_col  = '0;
								pend_d    = '0;
								pvld_d    = 1'b0;
								kd_d      = 1'b0;
							end
							do_place = cmd.is_letter;
						end
						CMD_FIN: begin
							if (!kd_q) begin
								go_fill = 1'b1;
								fidx_d  = '0;
							end
						end
						CMD_MSG: begin
							if (kd_q) begin
								if (!pvld_q) begin
									pend_d = cmd.idx;
									pvld_d = 1'b1;
								end else begin
									rc_rd_en = 1'b1;
									// doubled letter pairs with x and stays pending
									if (cmd.idx != pend_q) begin
										rd_b   = cmd.idx;
										pend_d = '0;
										pvld_d = 1'b0;
									end
								end
							end
						end
						default: begin
							if (kd_q && pvld_q) begin
								rc_rd_en = 1'b1;
								pend_d   = '0;
								pvld_d   = 1'b0;
							end
						end
					endcase
				end
			end
			BK_FILL: begin
				place_idx = fidx_q;
				do_place  = (fidx_q != LTR_J);
				fidx_d    = fidx_q + 5'd1;
				if (fidx_q == LTR_LAST) begin
					kd_d = 1'b1;
				end
			end
			BK_LOOK: sq_rd_en = 1'b1;
			default: ;
		endcase

		can_place = do_place && !base_used[place_idx] && (base_row < SIDE);
		wr_pos    = cell_pos(base_row, base_col);
		used_d    = base_used;
		frow_d    = base_row;
		fcol_d    = base_col;
		if (can_place) begin
			used_d = base_used | (N_LETTERS'(1) << place_idx);
			if (base_col == SIDE_MAX) begin
				fcol_d = '0;
				frow_d = base_row + 3'd1;
			end else begin
				fcol_d = base_col + 3'd1;
			end
		end
	end

	// cipher positions from the fetched row/col of both letters
	always_comb begin
		ra = rc_a_q[5:3];
		ca = rc_a_q[2:0];
		rb = rc_b_q[5:3];
		cb = rc_b_q[2:0];
		if (ra == rb) begin
			pos1 = cell_pos(ra, wrap_inc(ca));
			pos2 = cell_pos(rb, wrap_inc(cb));
		end else if (ca == cb) begin
			pos1 = cell_pos(wrap_inc(ra), ca);
			pos2 = cell_pos(wrap_inc(rb), cb);
		end else begin
			pos1 = cell_pos(ra, cb);
			pos2 = cell_pos(rb, ca);
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: begin
				if (go_fill) begin
					st_d = BK_FILL;
				end else if (rc_rd_en) begin
					st_d = BK_LOOK;
				end
			end
			BK_FILL: if (fidx_q == LTR_LAST) st_d = BK_IDLE;
			BK_LOOK: st_d = BK_OUT0;
			BK_OUT0: if (!result_stall) st_d = BK_OUT1;
			BK_OUT1: if (!result_stall) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		result_valid = (st_q == BK_OUT0) || (st_q == BK_OUT1);
		result.pair_last = (st_q == BK_OUT1);
		result.cipher_letter = OUT_BASE +
			{2'b00, ((st_q == BK_OUT1) ? sq2_q : sq1_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			used_q <= '0;
			frow_q <= '0;
			fcol_q <= '0;
			pend_q <= '0;
			pvld_q <= 1'b0;
			kd_q   <= 1'b0;
			fidx_q <= '0;
		end else begin
			st_q   <= st_d;
			used_q <= used_d;
			frow_q <= frow_d;
			fcol_q <= fcol_d;
			pend_q <= pend_d;
			pvld_q <= pvld_d;
			kd_q   <= kd_d;
			fidx_q <= fidx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (can_place) begin
			sq_mem[wr_pos]    <= place_idx;
			rc_mem[place_idx] <= {base_row, base_col};
		end
		if (rc_rd_en) begin
			rc_a_q <= rc_mem[pend_q];
			rc_b_q <= rc_mem[rd_b];
		end
		if (sq_rd_en) begin
			sq1_q <= sq_mem[pos1];
			sq2_q <= sq_mem[pos2];
		end
	end

	a_fill_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_FILL && fidx_q == LTR_LAST) |=> (frow_q == SIDE && fcol_q == 3'd0 && kd_q))
		else $error("square not full after fill sweep");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_OUT0 && !result_stall) |=> (result_valid && result.pair_last))
		else $error("second letter of pair missing");
	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.cipher_letter >= 7'd97 && result.cipher_letter <= 7'd122))
		else $error("cipher letter out of range");

endmodule

// ----- hw/rtl/playfair_cipher_encrypt_core.sv -----
// Playfair encrypt core: front accepts one transfer a cycle while the command queue is
// not full. Back end: a key letter or lone message letter is a single dequeue; finish key
// is a dequeue plus an alphabet sweep over all 26 letters; an encrypted pair takes a
// position read (at dequeue), a square read, then two output letters, each held through
// any output stall. Both reads are registered before the first cipher letter is valid.
// Reset clears queue, state and used-letter flags; square memories hold garbage until keyed.
module playfair_cipher_encrypt_core import pfc_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	push_t wr;
	logic  q_full, q_valid, pop;
	cmd_t  rd_cmd;

	pfc_front u_front (
		.item_valid (item_valid),
		.item       (item),
		.q_full     (q_full),
		.item_stall (item_stall),
		.wr         (wr)
	);

	pfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.pop     (pop),
		.full    (q_full),
		.q_valid (q_valid),
		.rd_cmd  (rd_cmd)
	);

	pfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.cmd          (rd_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
